>>> sv/fr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_pkg
// Shared widths and constants for the Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package fr_pkg;

  // Port field widths
  localparam int DIR_W  = 16;   // signed direction component
  localparam int IOR_W  = 15;   // unsigned Q2.13 index
  localparam int REFL_W = 16;   // unsigned Q1.15 reflectance

  // Default direction format
  localparam int DIR_FRAC_BITS_DEF = 14;

  // Internal fixed-point widths
  localparam int Q30_W  = 31;   // Q30 value up to 1.0 inclusive
  localparam int RAD_W  = 62;   // radicand of the square roots
  localparam int PROD_W = IOR_W + Q30_W;  // index times Q30 value
  localparam int SINT_W = 30;   // sint when no total internal reflection
  localparam int RAT_QB = 31;   // fraction bits of |Rs| and |Rp|
  localparam int RAT_W  = 32;   // |Rs|, |Rp| including the 1.0 case
  localparam int SQ_W   = 2 * RAT_W;

  // Iterations retired per pipeline stage in the sqrt and divide units
  localparam int STEPS_PER_STAGE = 2;

  // Constants
  localparam logic [RAD_W-1:0]  RAD_ONE   = RAD_W'(1) << 60;   // 1.0 in Q60
  localparam logic [RAT_W-1:0]  RAT_ONE   = RAT_W'(1) << 31;   // 1.0 in Q31
  localparam logic [SQ_W-1:0]   ROUND_Q62 = SQ_W'(1) << 46;    // half LSB of Q15
  localparam logic [REFL_W-1:0] REFL_ONE  = REFL_W'(32768);    // 1.0 in Q1.15

endpackage

>>> sv/fresnel_reflectance_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fresnel_reflectance_core
// Unpolarized Fresnel reflectance from incident direction, normal and two
// refractive indices, with total internal reflection flag.
//
//   channel  | handshake            | words
//   ---------+----------------------+------------------------------------------
//   input    | in_valid / in_ready  | inc_x/y/z, norm_x/y/z, ior_first/second
//   output   | out_valid/out_ready  | reflectance, total_internal
//
// One word per cycle unless the output stalls; at the default settings most of the
// depth lies in the two square root units (16 stages each) and the two divider
// banks (15 and 16 stages), two result bits per stage.
// A single advance enable moves every stage; the pipe holds when the output
// word waits and in_ready drops with it. Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module fresnel_reflectance_core #(
  parameter int DIR_FRAC_BITS = fr_pkg::DIR_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [fr_pkg::DIR_W-1:0]   inc_x,
  input  logic signed [fr_pkg::DIR_W-1:0]   inc_y,
  input  logic signed [fr_pkg::DIR_W-1:0]   inc_z,
  input  logic signed [fr_pkg::DIR_W-1:0]   norm_x,
  input  logic signed [fr_pkg::DIR_W-1:0]   norm_y,
  input  logic signed [fr_pkg::DIR_W-1:0]   norm_z,
  input  logic        [fr_pkg::IOR_W-1:0]   ior_first,
  input  logic        [fr_pkg::IOR_W-1:0]   ior_second,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic        [fr_pkg::REFL_W-1:0]  reflectance,
  output logic                              total_internal
);
  import fr_pkg::*;

  localparam int PW   = 2 * DIR_W;
  localparam int DOTW = PW + 2;
  localparam int DB   = 2 * DIR_FRAC_BITS;
  localparam int CW   = (DB + 2 > DOTW) ? DB + 2 : DOTW;
  localparam logic signed [CW-1:0] ONE_S = CW'(1) << DB;
  localparam int S1W  = Q30_W + 2 * IOR_W;
  localparam int S2W  = S1W + 1;

  logic en;
  assign en       = out_ready || !out_valid;
  assign in_ready = en;

  // Stage 1: component products
  logic                   v1;
  logic signed [PW-1:0]   px, py, pz;
  logic [IOR_W-1:0]       ei1, et1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px  <= inc_x * norm_x;
      py  <= inc_y * norm_y;
      pz  <= inc_z * norm_z;
      ei1 <= ior_first;
      et1 <= ior_second;
    end
  end

  // Stage 2: dot sum, clamp, index swap, |cosi| to Q30
  logic signed [CW-1:0] dot_c;
  logic        [CW-1:0] mag_c;
  logic [Q30_W-1:0]     c_c;
  logic                 v2;
  logic [Q30_W-1:0]     c2;
  logic [IOR_W-1:0]     ei2, et2;

  always_comb begin
    dot_c = CW'(DOTW'(px) + DOTW'(py) + DOTW'(pz));
    if (dot_c > ONE_S) begin
      dot_c = ONE_S;
    end else if (dot_c < -ONE_S) begin
      dot_c = -ONE_S;
    end
    mag_c = dot_c[CW-1] ? CW'(-dot_c) : CW'(dot_c);
  end

  if (DB >= 30) begin : g_c_down
    logic [CW-1:0] sh_c;
    assign sh_c = mag_c >> (DB - 30);
    assign c_c  = sh_c[Q30_W-1:0];
  end else begin : g_c_up
    logic [CW+Q30_W-1:0] sh_c;
    assign sh_c = (CW+Q30_W)'(mag_c) << (30 - DB);
    assign c_c  = sh_c[Q30_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c2 <= c_c;
      // leaving the medium: indices trade places
      if (!dot_c[CW-1] && (dot_c != '0)) begin
        ei2 <= et1;
        et2 <= ei1;
      end else begin
        ei2 <= ei1;
        et2 <= et1;
      end
    end
  end

  // Stage 3: radicand 1 - cosi^2
  logic             v3;
  logic [RAD_W-1:0] rad3;
  logic [S1W-1:0]   side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad3  <= RAD_ONE - RAD_W'(c2 * c2);
      side3 <= {c2, ei2, et2};
    end
  end

  // sini
  logic             vs1;
  logic [Q30_W-1:0] sini;
  logic [S1W-1:0]   side_s1;

  fr_sqrt #(.RTW(Q30_W), .SW(S1W), .SPS(STEPS_PER_STAGE)) u_sqrt_sini (
    .clk(clk), .rst(rst), .en(en),
    .in_v(v3), .in_rad(rad3), .in_side(side3),
    .out_v(vs1), .out_root(sini), .out_side(side_s1)
  );

  // Stage 4: etai * sini and total internal reflection test
  logic              v4;
  logic [PROD_W-1:0] p4;
  logic [Q30_W-1:0]  c4;
  logic [IOR_W-1:0]  ei4, et4;
  logic              tir4;
  logic [PROD_W-1:0] p_c;

  assign p_c = PROD_W'(side_s1[2*IOR_W-1 -: IOR_W] * sini);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vs1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p4   <= p_c;
      c4   <= side_s1[S1W-1 -: Q30_W];
      ei4  <= side_s1[2*IOR_W-1 -: IOR_W];
      et4  <= side_s1[IOR_W-1:0];
      tir4 <= p_c >= {1'b0, side_s1[IOR_W-1:0], 30'b0};
    end
  end

  // sint = etai * sini / etat
  logic              vd1;
  logic [SINT_W-1:0] sint;
  logic [S2W-1:0]    side_d1;

  fr_div #(.DW(IOR_W), .QB(SINT_W), .SW(S2W), .SPS(STEPS_PER_STAGE)) u_div_sint (
    .clk(clk), .rst(rst), .en(en),
    .in_v(v4), .in_rem(p4[PROD_W-1:SINT_W]), .in_low(p4[SINT_W-1:0]),
    .in_div(et4), .in_side({c4, ei4, et4, tir4}),
    .out_v(vd1), .out_quo(sint), .out_side(side_d1)
  );

  // Stage 5: radicand 1 - sint^2
  logic             v5;
  logic [RAD_W-1:0] rad5;
  logic [S2W-1:0]   side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= vd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad5  <= RAD_ONE - RAD_W'(sint * sint);
      side5 <= side_d1;
    end
  end

  // cost
  logic             vs2;
  logic [Q30_W-1:0] cost;
  logic [S2W-1:0]   side_s2;

  fr_sqrt #(.RTW(Q30_W), .SW(S2W), .SPS(STEPS_PER_STAGE)) u_sqrt_cost (
    .clk(clk), .rst(rst), .en(en),
    .in_v(v5), .in_rad(rad5), .in_side(side5),
    .out_v(vs2), .out_root(cost), .out_side(side_s2)
  );

  // Stage 6: the four index products
  logic              v6, tir6;
  logic [PROD_W-1:0] a1, b1, a2, b2;
  logic [Q30_W-1:0]  c_s2;
  logic [IOR_W-1:0]  ei_s2, et_s2;

  assign c_s2  = side_s2[S2W-1 -: Q30_W];
  assign ei_s2 = side_s2[2*IOR_W -: IOR_W];
  assign et_s2 = side_s2[IOR_W:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= vs2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1   <= PROD_W'(et_s2 * c_s2);
      b1   <= PROD_W'(ei_s2 * cost);
      a2   <= PROD_W'(ei_s2 * c_s2);
      b2   <= PROD_W'(et_s2 * cost);
      tir6 <= side_s2[0];
    end
  end

  // Stage 7: numerators, denominators, special cases
  logic              v7, tir7, zero7, eq1_7, eq2_7;
  logic [PROD_W:0]   n1, d1, n2, d2;
  logic [PROD_W:0]   n1_c, d1_c, n2_c, d2_c;

  always_comb begin
    n1_c = (a1 >= b1) ? {1'b0, a1 - b1} : {1'b0, b1 - a1};
    d1_c = {1'b0, a1} + {1'b0, b1};
    n2_c = (a2 >= b2) ? {1'b0, a2 - b2} : {1'b0, b2 - a2};
    d2_c = {1'b0, a2} + {1'b0, b2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1    <= n1_c;
      d1    <= d1_c;
      n2    <= n2_c;
      d2    <= d2_c;
      tir7  <= tir6;
      zero7 <= (d1_c == '0) || (d2_c == '0);
      eq1_7 <= n1_c >= d1_c;
      eq2_7 <= n2_c >= d2_c;
    end
  end

  // |Rs| and |Rp| in Q31
  logic              vq1, vq2;
  logic [RAT_QB-1:0] q1, q2;
  logic [2:0]        side_q1;
  logic              side_q2;

  fr_div #(.DW(PROD_W+1), .QB(RAT_QB), .SW(3), .SPS(STEPS_PER_STAGE)) u_div_rs (
    .clk(clk), .rst(rst), .en(en),
    .in_v(v7), .in_rem({1'b0, n1}), .in_low('0),
    .in_div(d1), .in_side({tir7, zero7, eq1_7}),
    .out_v(vq1), .out_quo(q1), .out_side(side_q1)
  );

  fr_div #(.DW(PROD_W+1), .QB(RAT_QB), .SW(1), .SPS(STEPS_PER_STAGE)) u_div_rp (
    .clk(clk), .rst(rst), .en(en),
    .in_v(v7), .in_rem({1'b0, n2}), .in_low('0),
    .in_div(d2), .in_side(eq2_7),
    .out_v(vq2), .out_quo(q2), .out_side(side_q2)
  );

  // Stage 8: squares
  logic             v8, tir8, zero8;
  logic [SQ_W-1:0]  rs2, rp2;
  logic [RAT_W-1:0] rs_c, rp_c;

  assign rs_c = side_q1[0] ? RAT_ONE : {1'b0, q1};
  assign rp_c = side_q2    ? RAT_ONE : {1'b0, q2};

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= vq1 && vq2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs2   <= rs_c * rs_c;
      rp2   <= rp_c * rp_c;
      tir8  <= side_q1[2];
      zero8 <= side_q1[1];
    end
  end

  // Stage 9: mean, round to Q15, saturate; output word
  logic [SQ_W-1:0]   mean_c, rnd_c;
  logic [REFL_W:0]   r_c;

  always_comb begin
    mean_c = (rs2 + rp2) >> 1;
    rnd_c  = (mean_c + ROUND_Q62) >> 47;
    r_c    = rnd_c[REFL_W:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v8;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      total_internal <= tir8;
      if (tir8 || zero8 || (r_c > {1'b0, REFL_ONE})) begin
        reflectance <= REFL_ONE;
      end else begin
        reflectance <= r_c[REFL_W-1:0];
      end
    end
  end

endmodule

>>> sv/fr_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_sqrt
// Pipelined digit-by-digit integer square root, floor(sqrt(rad)).
// A side word travels with each radicand.
// ----------------------------------------------------------------------------
module fr_sqrt #(
  parameter int RTW = 31,
  parameter int SW  = 1,
  parameter int SPS = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_v,
  input  logic [2*RTW-1:0] in_rad,
  input  logic [SW-1:0]    in_side,
  output logic             out_v,
  output logic [RTW-1:0]   out_root,
  output logic [SW-1:0]    out_side
);
  localparam int RW  = 2 * RTW;
  localparam int RMW = RTW + 2;
  localparam int NST = (RTW + SPS - 1) / SPS;

  wire [NST:0]                v_w;
  wire [NST:0][RW-1:0]        rad_w;
  wire [NST:0][RMW-1:0]       rem_w;
  wire [NST:0][RTW-1:0]       root_w;
  wire [NST:0][SW-1:0]        side_w;

  assign v_w[0]    = in_v;
  assign rad_w[0]  = in_rad;
  assign rem_w[0]  = '0;
  assign root_w[0] = '0;
  assign side_w[0] = in_side;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [RW-1:0]  rad_c,  rad_r;
    logic [RMW-1:0] rem_c,  rem_r;
    logic [RTW-1:0] root_c, root_r;
    logic [SW-1:0]  side_r;
    logic           v_r;

    // one result bit per iteration
    always_comb begin
      rad_c  = rad_w[k];
      rem_c  = rem_w[k];
      root_c = root_w[k];
      for (int j = 0; j < SPS; j++) begin
        if (k * SPS + j < RTW) begin
          rem_c = {rem_c[RMW-3:0], rad_c[RW-1 -: 2]};
          if (rem_c >= {root_c, 2'b01}) begin
            rem_c  = rem_c - {root_c, 2'b01};
            root_c = {root_c[RTW-2:0], 1'b1};
          end else begin
            root_c = {root_c[RTW-2:0], 1'b0};
          end
          rad_c = rad_c << 2;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r  <= rad_c;
        rem_r  <= rem_c;
        root_r <= root_c;
        side_r <= side_w[k];
      end
    end

    assign v_w[k+1]    = v_r;
    assign rad_w[k+1]  = rad_r;
    assign rem_w[k+1]  = rem_r;
    assign root_w[k+1] = root_r;
    assign side_w[k+1] = side_r;
  end

  assign out_v    = v_w[NST];
  assign out_root = root_w[NST];
  assign out_side = side_w[NST];

endmodule

>>> sv/fr_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_div
// Pipelined restoring divider. The user must give a partial remainder below the
// divisor (not enforced here); it shifts in QB low bits, giving QB quotient bits.
// ----------------------------------------------------------------------------
module fr_div #(
  parameter int DW  = 15,
  parameter int QB  = 30,
  parameter int SW  = 1,
  parameter int SPS = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_v,
  input  logic [DW:0]   in_rem,
  input  logic [QB-1:0] in_low,
  input  logic [DW-1:0] in_div,
  input  logic [SW-1:0] in_side,
  output logic          out_v,
  output logic [QB-1:0] out_quo,
  output logic [SW-1:0] out_side
);
  localparam int NST = (QB + SPS - 1) / SPS;

  wire [NST:0]            v_w;
  wire [NST:0][DW:0]      rem_w;
  wire [NST:0][QB-1:0]    low_w;
  wire [NST:0][QB-1:0]    quo_w;
  wire [NST:0][DW-1:0]    div_w;
  wire [NST:0][SW-1:0]    side_w;

  assign v_w[0]    = in_v;
  assign rem_w[0]  = in_rem;
  assign low_w[0]  = in_low;
  assign quo_w[0]  = '0;
  assign div_w[0]  = in_div;
  assign side_w[0] = in_side;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    logic [DW+1:0]  trial;
    logic [DW:0]    rem_c, rem_r;
    logic [QB-1:0]  low_c, low_r;
    logic [QB-1:0]  quo_c, quo_r;
    logic [DW-1:0]  div_r;
    logic [SW-1:0]  side_r;
    logic           v_r;

    // one quotient bit per iteration
    always_comb begin
      trial = '0;
      rem_c = rem_w[k];
      low_c = low_w[k];
      quo_c = quo_w[k];
      for (int j = 0; j < SPS; j++) begin
        if (k * SPS + j < QB) begin
          trial = {rem_c, low_c[QB-1]};
          if (trial >= {2'b00, div_w[k]}) begin
            rem_c = (DW+1)'(trial - {2'b00, div_w[k]});
            quo_c = {quo_c[QB-2:0], 1'b1};
          end else begin
            rem_c = trial[DW:0];
            quo_c = {quo_c[QB-2:0], 1'b0};
          end
          low_c = low_c << 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= v_w[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= rem_c;
        low_r  <= low_c;
        quo_r  <= quo_c;
        div_r  <= div_w[k];
        side_r <= side_w[k];
      end
    end

    assign v_w[k+1]    = v_r;
    assign rem_w[k+1]  = rem_r;
    assign low_w[k+1]  = low_r;
    assign quo_w[k+1]  = quo_r;
    assign div_w[k+1]  = div_r;
    assign side_w[k+1] = side_r;
  end

  assign out_v    = v_w[NST];
  assign out_quo  = quo_w[NST];
  assign out_side = side_w[NST];

endmodule

>>> sv/fr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fr_checker
// Port-level checks for the Fresnel reflectance core, bound to the top.
// ----------------------------------------------------------------------------
module fr_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [fr_pkg::REFL_W-1:0]    reflectance,
  input logic                         total_internal
);
  import fr_pkg::*;

  // a stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(reflectance)
      && $stable(total_internal))
    else $error("output word changed while stalled");

  // total internal reflection always reports full reflectance
  a_tir_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && total_internal |-> reflectance == REFL_ONE)
    else $error("total internal reflection without full reflectance");

  // reflectance never exceeds 1.0
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> reflectance <= REFL_ONE)
    else $error("reflectance above 1.0");

  // pipe freezes while the output word waits
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipe is frozen");

endmodule

bind fresnel_reflectance_core fr_checker u_fr_checker (.*);
